// File: rtl/gsqr_pkg.sv
`timescale 1ns / 1ps
package gsqr_pkg;

  // widest word address over the parameter range (32 x 32 entries)
  localparam int unsigned ADDR_MAX_W = 10;

  // controller states
  typedef enum logic [4:0] {
    ST_LOAD,
    ST_NRM_RD,
    ST_NRM_MUL,
    ST_NRM_ACC,
    ST_SQRT,
    ST_SQRT_WAIT,
    ST_DIAG,
    ST_QZ_WR,
    ST_QN_RD,
    ST_QN_LAT,
    ST_QN_WAIT,
    ST_QN_WR,
    ST_DOT_RD,
    ST_DOT_MUL,
    ST_DOT_ACC,
    ST_DOT_WR,
    ST_UPD_RD,
    ST_UPD_MUL,
    ST_UPD_SHF,
    ST_UPD_WR,
    ST_OUT_RD,
    ST_OUT_LAT,
    ST_OUT_WAIT
  } state_e;

  // datapath actions
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_SQ_ACC,
    ACT_SQRT_GO,
    ACT_DIAG_WR,
    ACT_QZ_WR,
    ACT_DIV_GO,
    ACT_Q_WR,
    ACT_DOT_ACC,
    ACT_DOT_WR,
    ACT_UPD_SHF,
    ACT_UPD_WR,
    ACT_OUT_LOAD
  } act_e;

  // multiplier operand selection
  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_SQ,
    MUL_QB,
    MUL_DQ
  } mul_e;

  typedef struct packed {
    act_e                  act;
    mul_e                  mul;
    logic                  rd;
    logic                  first;
    logic [ADDR_MAX_W-1:0] addr_a;
    logic [ADDR_MAX_W-1:0] addr_b;
    logic [ADDR_MAX_W-1:0] u_addr;
    logic [2:0]            out_row;
    logic [2:0]            out_col;
    logic                  out_last;
  } cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic div_done;
    logic norm_zero;
  } sts_t;

endpackage

// File: rtl/gsqr_dp.sv
`timescale 1ns / 1ps
module gsqr_dp #(
  parameter int unsigned MAX_ROWS  = 8,
  parameter int unsigned MAX_COLS  = 8,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gsqr_pkg::cmd_t      cmd_i,
  input  logic signed [31:0]  in_value_i,
  output gsqr_pkg::sts_t      sts_o,
  output logic [2:0]          out_row_o,
  output logic [2:0]          out_col_o,
  output logic signed [31:0]  q_value_o,
  output logic signed [31:0]  r_value_o,
  output logic                singular_o,
  output logic                out_last_o
);
  import gsqr_pkg::*;

  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned DVW   = 32 + FRAC_BITS;
  localparam int unsigned DCW   = $clog2(DVW);

  // truncate toward zero on magnitude
  function automatic logic signed [63:0] shr_frac(input logic signed [63:0] v);
    logic [63:0] mag;
    logic [63:0] m;
    mag = v[63] ? (~v + 64'd1) : v;
    m   = mag >> FRAC_BITS;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [31:0] sat32_64(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    else if (v < -64'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  logic [AW-1:0] addr_a, addr_b, u_addr;
  assign addr_a = cmd_i.addr_a[AW-1:0];
  assign addr_b = cmd_i.addr_b[AW-1:0];
  assign u_addr = cmd_i.u_addr[AW-1:0];

  // storage
  logic signed [31:0] col_mem [DEPTH];
  logic signed [31:0] up_mem  [DEPTH];
  logic signed [31:0] rda_q, rdb_q, rdu_q;

  // arithmetic registers
  logic [63:0]        prod_q, acc_q;
  logic signed [63:0] p_q;
  logic signed [31:0] dot_q;
  logic               sing_q;

  // square root unit
  logic [63:0] rad_q;
  logic [31:0] root_q;
  logic [33:0] srem_q;
  logic [4:0]  scnt_q;
  logic        sbusy_q, sdone_q;
  logic [30:0] norm_q;

  // divider unit
  logic [DVW-1:0] dvd_q, quo_q;
  logic [32:0]    drem_q;
  logic [DCW-1:0] dcnt_q;
  logic           dbusy_q, ddone_q, dneg_q;

  // column store and upper store ports
  logic signed [31:0] q_sat, upd_val;
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rda_q <= col_mem[addr_a];
      rdb_q <= col_mem[addr_b];
      rdu_q <= up_mem[u_addr];
    end
    unique case (cmd_i.act)
      ACT_LOAD:    col_mem[addr_a] <= in_value_i;
      ACT_QZ_WR:   col_mem[addr_a] <= '0;
      ACT_Q_WR:    col_mem[addr_a] <= q_sat;
      ACT_UPD_WR:  col_mem[addr_b] <= upd_val;
      ACT_DIAG_WR: up_mem[u_addr]  <= {1'b0, norm_q};
      ACT_DOT_WR:  up_mem[u_addr]  <= sat32_64(shr_frac(acc_q));
      default: ;
    endcase
  end

  // shared multiplier
  logic [31:0]        mag_a;
  logic signed [32:0] op_x, op_y;
  logic signed [65:0] mul_full;
  assign mag_a = rda_q[31] ? (~rda_q + 32'd1) : rda_q;
  always_comb begin
    unique case (cmd_i.mul)
      MUL_SQ: begin
        op_x = {1'b0, mag_a};
        op_y = {1'b0, mag_a};
      end
      MUL_QB: begin
        op_x = {rda_q[31], rda_q};
        op_y = {rdb_q[31], rdb_q};
      end
      MUL_DQ: begin
        op_x = {dot_q[31], dot_q};
        op_y = {rda_q[31], rda_q};
      end
      default: begin
        op_x = '0;
        op_y = '0;
      end
    endcase
  end
  assign mul_full = op_x * op_y;

  // accumulate paths
  logic [64:0]        usum;
  logic signed [63:0] sbase, ssum;
  logic               sovf;
  assign usum  = {1'b0, (cmd_i.first ? 64'd0 : acc_q)} + {1'b0, prod_q};
  assign sbase = cmd_i.first ? 64'sd0 : $signed(acc_q);
  assign ssum  = sbase + $signed(prod_q);
  assign sovf  = (sbase[63] == prod_q[63]) && (ssum[63] != sbase[63]);

  // quotient saturation and column update
  logic               qbig;
  logic signed [64:0] upd_full;
  assign qbig    = |quo_q[DVW-1:31];
  assign q_sat   = dneg_q ? (qbig ? 32'sh80000000 : -$signed(quo_q[31:0]))
                          : (qbig ? 32'sh7fffffff : $signed(quo_q[31:0]));
  assign upd_full = {{33{rdb_q[31]}}, rdb_q} - {p_q[63], p_q};
  assign upd_val  = (upd_full > 65'sd2147483647) ? 32'sh7fffffff :
                    (upd_full < -65'sd2147483648) ? 32'sh80000000 : upd_full[31:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul != MUL_NONE) prod_q <= mul_full[63:0];
    unique case (cmd_i.act)
      ACT_SQ_ACC:  acc_q <= usum[64] ? '1 : usum[63:0];
      ACT_DOT_ACC: acc_q <= sovf ? (sbase[63] ? 64'h8000000000000000
                                              : 64'h7fffffffffffffff) : ssum;
      ACT_DOT_WR:  dot_q <= sat32_64(shr_frac(acc_q));
      ACT_UPD_SHF: p_q   <= shr_frac(prod_q);
      default: ;
    endcase
  end

  // singular flag, cleared as a decomposition starts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sing_q <= 1'b0;
    end else if (cmd_i.act == ACT_LOAD && cmd_i.first) begin
      sing_q <= 1'b0;
    end else if (cmd_i.act == ACT_DIAG_WR && norm_q == '0) begin
      sing_q <= 1'b1;
    end
  end

  // digit-pair square root, two radicand bits per cycle
  logic [33:0] s_shift, s_trial;
  assign s_shift = {srem_q[31:0], rad_q[63:62]};
  assign s_trial = {root_q, 2'b01};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sbusy_q <= 1'b0;
      sdone_q <= 1'b0;
      scnt_q  <= '0;
    end else if (cmd_i.act == ACT_SQRT_GO) begin
      sbusy_q <= 1'b1;
      sdone_q <= 1'b0;
      scnt_q  <= '0;
    end else if (sbusy_q) begin
      scnt_q <= scnt_q + 5'd1;
      if (scnt_q == 5'd31) begin
        sbusy_q <= 1'b0;
        sdone_q <= 1'b1;
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.act == ACT_SQRT_GO) begin
      rad_q  <= acc_q;
      root_q <= '0;
      srem_q <= '0;
    end else if (sbusy_q) begin
      rad_q <= {rad_q[61:0], 2'b00};
      if (s_shift >= s_trial) begin
        srem_q <= s_shift - s_trial;
        root_q <= {root_q[30:0], 1'b1};
      end else begin
        srem_q <= s_shift;
        root_q <= {root_q[30:0], 1'b0};
      end
      if (scnt_q == 5'd31) begin
        // last root bit lands in the same cycle
        norm_q <= (root_q[30] ? 31'h7fffffff
                  : {root_q[29:0], (s_shift >= s_trial)});
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [32:0] d_shift;
  assign d_shift = {drem_q[31:0], dvd_q[DVW-1]};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      ddone_q <= 1'b0;
      dcnt_q  <= '0;
    end else if (cmd_i.act == ACT_DIV_GO) begin
      dbusy_q <= 1'b1;
      ddone_q <= 1'b0;
      dcnt_q  <= '0;
    end else if (dbusy_q) begin
      dcnt_q <= dcnt_q + DCW'(1);
      if (dcnt_q == DCW'(DVW - 1)) begin
        dbusy_q <= 1'b0;
        ddone_q <= 1'b1;
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.act == ACT_DIV_GO) begin
      dvd_q  <= {mag_a, {FRAC_BITS{1'b0}}};
      quo_q  <= '0;
      drem_q <= '0;
      dneg_q <= rda_q[31];
    end else if (dbusy_q) begin
      dvd_q <= {dvd_q[DVW-2:0], 1'b0};
      if (d_shift >= {2'b00, norm_q}) begin
        drem_q <= d_shift - {2'b00, norm_q};
        quo_q  <= {quo_q[DVW-2:0], 1'b1};
      end else begin
        drem_q <= d_shift;
        quo_q  <= {quo_q[DVW-2:0], 1'b0};
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.act == ACT_OUT_LOAD) begin
      out_row_o  <= cmd_i.out_row;
      out_col_o  <= cmd_i.out_col;
      q_value_o  <= rda_q;
      r_value_o  <= (cmd_i.out_row <= cmd_i.out_col) ? rdu_q : '0;
      singular_o <= sing_q;
      out_last_o <= cmd_i.out_last;
    end
  end

  assign sts_o.sqrt_done = sdone_q;
  assign sts_o.div_done  = ddone_q;
  assign sts_o.norm_zero = (norm_q == '0);

endmodule

// File: rtl/gsqr_ctrl.sv
`timescale 1ns / 1ps
module gsqr_ctrl #(
  parameter int unsigned MAX_ROWS = 8,
  parameter int unsigned MAX_COLS = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [3:0]     n_rows_i,
  input  logic [3:0]     n_cols_i,
  input  logic           in_valid_i,
  input  logic           in_last_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  gsqr_pkg::sts_t sts_i,
  output gsqr_pkg::cmd_t cmd_o
);
  import gsqr_pkg::*;

  localparam int unsigned AW   = $clog2(MAX_ROWS * MAX_COLS);
  localparam int unsigned IW   = $clog2(MAX_ROWS);
  localparam int unsigned JW   = $clog2(MAX_COLS);
  localparam int unsigned CNTW = $clog2(MAX_ROWS + 1);
  localparam int unsigned CCW  = $clog2(MAX_COLS + 1);

  state_e         state_q, state_d;
  logic [IW-1:0]  i_q, i_d;
  logic [JW-1:0]  j_q, j_d, k_q, k_d;
  logic [AW-1:0]  lcnt_q, lcnt_d;

  // clamped sizes
  logic [CNTW-1:0] rows;
  logic [CCW-1:0]  cols;
  always_comb begin
    int unsigned r, c;
    r = (n_rows_i == 4'd0) ? 1 : int'(n_rows_i);
    if (r > MAX_ROWS) r = MAX_ROWS;
    c = (n_cols_i == 4'd0) ? 1 : int'(n_cols_i);
    if (c > MAX_COLS) c = MAX_COLS;
    if (c > r) c = r;
    rows = CNTW'(r);
    cols = CCW'(c);
  end

  logic i_last, j_last, k_last, s_fire;
  assign i_last = (CNTW'(i_q) + CNTW'(1)) == rows;
  assign j_last = (CCW'(j_q) + CCW'(1)) == cols;
  assign k_last = (CCW'(k_q) + CCW'(1)) == cols;
  assign s_fire = in_valid_i && in_ready_o;

  // store addresses
  logic [AW-1:0] top, idx, a_addr, b_addr, diag_addr, dot_addr, out_addr;
  assign top       = AW'(rows) * AW'(cols) - AW'(1);
  assign idx       = (lcnt_q > top) ? top : lcnt_q;
  assign a_addr    = AW'(j_q) * AW'(rows) + AW'(i_q);
  assign b_addr    = AW'(k_q) * AW'(rows) + AW'(i_q);
  assign diag_addr = AW'(j_q) * AW'(MAX_COLS) + AW'(j_q);
  assign dot_addr  = AW'(j_q) * AW'(MAX_COLS) + AW'(k_q);
  assign out_addr  = AW'(i_q) * AW'(MAX_COLS) + AW'(j_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      lcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      lcnt_q  <= lcnt_d;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_d        = state_q;
    i_d            = i_q;
    j_d            = j_q;
    k_d            = k_q;
    lcnt_d         = lcnt_q;
    in_ready_o     = 1'b0;
    out_valid_o    = 1'b0;
    cmd_o          = '0;
    cmd_o.act      = ACT_NONE;
    cmd_o.mul      = MUL_NONE;
    cmd_o.addr_a   = ADDR_MAX_W'(a_addr);
    cmd_o.addr_b   = ADDR_MAX_W'(b_addr);
    cmd_o.u_addr   = ADDR_MAX_W'(dot_addr);
    cmd_o.first    = (i_q == '0);
    cmd_o.out_row  = 3'(i_q);
    cmd_o.out_col  = 3'(j_q);
    cmd_o.out_last = i_last && j_last;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o   = 1'b1;
        cmd_o.addr_a = ADDR_MAX_W'(idx);
        cmd_o.first  = in_last_i;
        if (s_fire) begin
          cmd_o.act = ACT_LOAD;
          lcnt_d    = (idx < top) ? idx + AW'(1) : top;
          if (in_last_i) begin
            lcnt_d  = '0;
            i_d     = '0;
            j_d     = '0;
            state_d = ST_NRM_RD;
          end
        end
      end
      ST_NRM_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_NRM_MUL;
      end
      ST_NRM_MUL: begin
        cmd_o.mul = MUL_SQ;
        state_d   = ST_NRM_ACC;
      end
      ST_NRM_ACC: begin
        cmd_o.act = ACT_SQ_ACC;
        if (i_last) begin
          i_d     = '0;
          state_d = ST_SQRT;
        end else begin
          i_d     = i_q + IW'(1);
          state_d = ST_NRM_RD;
        end
      end
      ST_SQRT: begin
        cmd_o.act = ACT_SQRT_GO;
        state_d   = ST_SQRT_WAIT;
      end
      ST_SQRT_WAIT: begin
        if (sts_i.sqrt_done) state_d = ST_DIAG;
      end
      ST_DIAG: begin
        cmd_o.act    = ACT_DIAG_WR;
        cmd_o.u_addr = ADDR_MAX_W'(diag_addr);
        state_d      = sts_i.norm_zero ? ST_QZ_WR : ST_QN_RD;
      end
      ST_QZ_WR, ST_QN_WR: begin
        cmd_o.act = (state_q == ST_QZ_WR) ? ACT_QZ_WR : ACT_Q_WR;
        if (!i_last) begin
          i_d     = i_q + IW'(1);
          state_d = (state_q == ST_QZ_WR) ? ST_QZ_WR : ST_QN_RD;
        end else begin
          i_d = '0;
          if (j_last) begin
            j_d     = '0;
            state_d = ST_OUT_RD;
          end else begin
            k_d     = j_q + JW'(1);
            state_d = ST_DOT_RD;
          end
        end
      end
      ST_QN_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_QN_LAT;
      end
      ST_QN_LAT: begin
        cmd_o.act = ACT_DIV_GO;
        state_d   = ST_QN_WAIT;
      end
      ST_QN_WAIT: begin
        if (sts_i.div_done) state_d = ST_QN_WR;
      end
      ST_DOT_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_DOT_MUL;
      end
      ST_DOT_MUL: begin
        cmd_o.mul = MUL_QB;
        state_d   = ST_DOT_ACC;
      end
      ST_DOT_ACC: begin
        cmd_o.act = ACT_DOT_ACC;
        if (i_last) begin
          i_d     = '0;
          state_d = ST_DOT_WR;
        end else begin
          i_d     = i_q + IW'(1);
          state_d = ST_DOT_RD;
        end
      end
      ST_DOT_WR: begin
        cmd_o.act = ACT_DOT_WR;
        state_d   = ST_UPD_RD;
      end
      ST_UPD_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_UPD_MUL;
      end
      ST_UPD_MUL: begin
        cmd_o.mul = MUL_DQ;
        state_d   = ST_UPD_SHF;
      end
      ST_UPD_SHF: begin
        cmd_o.act = ACT_UPD_SHF;
        state_d   = ST_UPD_WR;
      end
      ST_UPD_WR: begin
        cmd_o.act = ACT_UPD_WR;
        if (!i_last) begin
          i_d     = i_q + IW'(1);
          state_d = ST_UPD_RD;
        end else begin
          i_d = '0;
          if (k_last) begin
            j_d     = j_q + JW'(1);
            state_d = ST_NRM_RD;
          end else begin
            k_d     = k_q + JW'(1);
            state_d = ST_DOT_RD;
          end
        end
      end
      ST_OUT_RD: begin
        cmd_o.rd     = 1'b1;
        cmd_o.u_addr = ADDR_MAX_W'(out_addr);
        state_d      = ST_OUT_LAT;
      end
      ST_OUT_LAT: begin
        cmd_o.act = ACT_OUT_LOAD;
        state_d   = ST_OUT_WAIT;
      end
      ST_OUT_WAIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (i_last && j_last) begin
            i_d     = '0;
            j_d     = '0;
            state_d = ST_LOAD;
          end else if (i_last) begin
            i_d     = '0;
            j_d     = j_q + JW'(1);
            state_d = ST_OUT_RD;
          end else begin
            i_d     = i_q + IW'(1);
            state_d = ST_OUT_RD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // input and output sides never open together
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("input and output open together");

  // the final element closes the input side
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && in_last_i) |=> !in_ready_o) else $error("load continued after last");

  // diagonal is written only after the root unit finished
  a_sqrt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIAG) |-> $past(sts_i.sqrt_done)) else $error("diag before root");

  // a quotient is written only after the divider finished
  a_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_QN_WR) |-> $past(sts_i.div_done)) else $error("q before divide");

endmodule

// File: rtl/gram_schmidt_qr_decompose.sv
`timescale 1ns / 1ps
// loading: one element per cycle, no results until the element marked last
// decomposition: per column, the norm accumulation, the root unit, the diagonal write, the
// shared bit-serial divider for each row (a zero norm writes zeros instead), then a dot
// product and update pass per later column
// results: one at a time, each held until the sink takes it, column-major
// asynchronous active-low reset; the stores keep no reset and need no clearing pass
module gram_schmidt_qr_decompose #(
  parameter int unsigned MAX_ROWS  = 8,
  parameter int unsigned MAX_COLS  = 8,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // in_value
  input  logic        s_axis_tlast,   // in_last
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // out_row, out_col, q_value, r_value, zero pad
  output logic [0:0]  m_axis_tuser,   // singular
  output logic        m_axis_tlast    // out_last
);
  import gsqr_pkg::*;

  logic [3:0] n_rows_q, n_cols_q;
  cmd_t       cmd;
  sts_t       sts;

  // register file
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_rows_q <= 4'd8;
      n_cols_q <= 4'd8;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) n_cols_q <= pwdata[3:0];
      else          n_rows_q <= pwdata[3:0];
    end
  end
  assign prdata = {28'd0, (paddr[2] ? n_cols_q : n_rows_q)};

  gsqr_ctrl #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .n_rows_i    (n_rows_q),
    .n_cols_i    (n_cols_q),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  logic [2:0]         out_row, out_col;
  logic signed [31:0] q_value, r_value;
  logic               singular, out_last;

  gsqr_dp #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_value_i (s_axis_tdata),
    .sts_o      (sts),
    .out_row_o  (out_row),
    .out_col_o  (out_col),
    .q_value_o  (q_value),
    .r_value_o  (r_value),
    .singular_o (singular),
    .out_last_o (out_last)
  );

  assign m_axis_tdata = {2'b00, r_value, q_value, out_col, out_row};
  assign m_axis_tuser = singular;
  assign m_axis_tlast = out_last;

endmodule

// File: sim/gram_schmidt_qr_decompose_tb.sv
`timescale 1ns / 1ps
module gram_schmidt_qr_decompose_tb;

  localparam int unsigned MAX_ROWS    = 8;
  localparam int unsigned MAX_COLS    = 8;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned STORE_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned REG_N_ROWS  = 0;
  localparam int unsigned REG_N_COLS  = 1;
  localparam int unsigned ITEM_TARGET = 370;
  localparam int unsigned IDLE_LIMIT  = 100000;
  localparam int unsigned SETTLE      = 40;
  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  typedef struct {
    logic [31:0] value;
    logic        last;
  } element_t;

  typedef struct {
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] q;
    logic [31:0] r;
    logic        singular;
    logic        last;
  } qr_entry_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // in_value
  logic        s_axis_tlast;   // in_last
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;   // out_row, out_col, q_value, r_value, zero pad
  logic [0:0]  m_axis_tuser;   // singular
  logic        m_axis_tlast;   // out_last

  gram_schmidt_qr_decompose uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // predictor state
  logic [3:0]         rows_reg;
  logic [3:0]         cols_reg;
  logic signed [31:0] col_mem [STORE_DEPTH];
  logic signed [31:0] upper_mem [STORE_DEPTH];
  int unsigned        load_idx;
  logic               zero_norm;

  element_t  pending_q [$];
  qr_entry_t qr_expected [$];
  int unsigned error_count;
  int unsigned items_queued;
  int unsigned idle_cycles;
  bit          elem_taken;

  function automatic logic signed [31:0] sat32(longint v);
    if (v > longint'(S32_MAX)) return S32_MAX;
    if (v < longint'(S32_MIN)) return S32_MIN;
    return v[31:0];
  endfunction

  function automatic longint sat_add64(longint a, longint b);
    longint s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) return a[63] ? 64'sh8000000000000000
                                                      : 64'sh7fffffffffffffff;
    return s;
  endfunction

  // shift right by magnitude, truncating toward zero
  function automatic longint frac_shift(longint v);
    logic [63:0] m;
    m = v[63] ? (64'd0 - v) : v;
    m = m >> FRAC_BITS;
    return v[63] ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic int unsigned rows_in_use();
    int unsigned r;
    r = rows_reg;
    if (r < 1) r = 1;
    if (r > MAX_ROWS) r = MAX_ROWS;
    return r;
  endfunction

  function automatic int unsigned cols_in_use();
    int unsigned c;
    c = cols_reg;
    if (c < 1) c = 1;
    if (c > MAX_COLS) c = MAX_COLS;
    if (c > rows_in_use()) c = rows_in_use();
    return c;
  endfunction

  // modified gram-schmidt on the column store, in place
  task automatic orthonormalize(int unsigned rows, int unsigned cols);
    logic [63:0] ss;
    logic [63:0] m;
    logic [63:0] sq;
    logic [63:0] qm;
    longint      qs;
    longint      acc;
    logic signed [31:0] nrm;
    logic signed [31:0] dot;
    for (int i = 0; i < STORE_DEPTH; i++) upper_mem[i] = 0;
    zero_norm = 1'b0;
    for (int j = 0; j < cols; j++) begin
      ss = 0;
      for (int i = 0; i < rows; i++) begin
        m  = col_mem[j*rows+i][31] ? 64'(-longint'(col_mem[j*rows+i]))
                                   : 64'(col_mem[j*rows+i]);
        sq = m * m;
        ss = (ss > ~sq) ? 64'hffffffffffffffff : ss + sq;
      end
      nrm = sat32(longint'(floor_sqrt(ss)));
      upper_mem[j*MAX_COLS+j] = nrm;
      if (nrm == 0) begin
        zero_norm = 1'b1;
        for (int i = 0; i < rows; i++) col_mem[j*rows+i] = 0;
      end else begin
        for (int i = 0; i < rows; i++) begin
          m  = col_mem[j*rows+i][31] ? 64'(-longint'(col_mem[j*rows+i]))
                                     : 64'(col_mem[j*rows+i]);
          qm = (m << FRAC_BITS) / 64'(nrm);
          qs = (qm > 64'h80000000) ? 64'sh80000000 : longint'(qm);
          col_mem[j*rows+i] = sat32(col_mem[j*rows+i][31] ? -qs : qs);
        end
      end
      for (int k = j + 1; k < cols; k++) begin
        acc = 0;
        for (int i = 0; i < rows; i++)
          acc = sat_add64(acc, longint'(col_mem[j*rows+i]) * longint'(col_mem[k*rows+i]));
        dot = sat32(frac_shift(acc));
        upper_mem[j*MAX_COLS+k] = dot;
        for (int i = 0; i < rows; i++)
          col_mem[k*rows+i] = sat32(longint'(col_mem[k*rows+i])
                                    - frac_shift(longint'(dot) * longint'(col_mem[j*rows+i])));
      end
    end
  endtask

  // store one element, on the last one queue the q/r entries
  task automatic predict_factors(element_t e);
    int unsigned rows;
    int unsigned cols;
    int unsigned top;
    int unsigned idx;
    qr_entry_t   x;
    rows = rows_in_use();
    cols = cols_in_use();
    top  = rows * cols - 1;
    idx  = (load_idx > top) ? top : load_idx;
    col_mem[idx] = e.value;
    load_idx = (idx < top) ? idx + 1 : top;
    if (e.last) begin
      orthonormalize(rows, cols);
      load_idx = 0;
      for (int c = 0; c < cols; c++) begin
        for (int r = 0; r < rows; r++) begin
          x.row      = r[2:0];
          x.col      = c[2:0];
          x.q        = col_mem[c*rows+r];
          x.r        = (r < cols) ? upper_mem[r*MAX_COLS+c] : 32'd0;
          x.singular = zero_norm;
          x.last     = (c == cols - 1 && r == rows - 1);
          qr_expected.push_back(x);
        end
      end
    end
  endtask

  task automatic report_mismatch(string what);
    $display("%0t mismatch: %s", $realtime, what);
    error_count++;
  endtask

  // input side: acceptance feeds the predictor
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      element_t e;
      e.value = s_axis_tdata;
      e.last  = s_axis_tlast;
      predict_factors(e);
      elem_taken = 1'b1;
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      qr_entry_t x;
      if (qr_expected.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        x = qr_expected.pop_front();
        if (m_axis_tdata[2:0] !== x.row)
          report_mismatch($sformatf("row %0d exp %0d", m_axis_tdata[2:0], x.row));
        if (m_axis_tdata[5:3] !== x.col)
          report_mismatch($sformatf("col %0d exp %0d", m_axis_tdata[5:3], x.col));
        if (m_axis_tdata[37:6] !== x.q)
          report_mismatch($sformatf("q(%0d,%0d) %h exp %h", x.row, x.col,
                                    m_axis_tdata[37:6], x.q));
        if (m_axis_tdata[69:38] !== x.r)
          report_mismatch($sformatf("r(%0d,%0d) %h exp %h", x.row, x.col,
                                    m_axis_tdata[69:38], x.r));
        if (m_axis_tuser[0] !== x.singular)
          report_mismatch($sformatf("singular %b exp %b", m_axis_tuser[0], x.singular));
        if (m_axis_tlast !== x.last)
          report_mismatch($sformatf("last %b exp %b", m_axis_tlast, x.last));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("gram_schmidt_qr_decompose test failed");
      $finish;
    end
  end

  // element driver: bursts with random gaps
  int unsigned burst_left;
  int unsigned gap_left;
  always @(negedge clk_i) begin
    element_t e;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!(s_axis_tvalid && !elem_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        e = pending_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= e.value;
        s_axis_tlast  <= e.last;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    elem_taken = 1'b0;
  end

  // result sink: stall pattern cycles through several modes
  int unsigned sink_cycle;
  always @(negedge clk_i) begin
    sink_cycle++;
    case ((sink_cycle / 97) % 4)
      0: begin
        m_axis_tready <= 1'b1;
      end
      1: begin
        m_axis_tready <= $urandom_range(0, 1);
      end
      2: begin
        m_axis_tready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        m_axis_tready <= ($urandom_range(0, 9) != 0);
      end
    endcase
  end

  task automatic write_reg(int unsigned idx, logic [3:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * idx);
    pwdata  <= {28'd0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_N_ROWS) rows_reg = val;
    else cols_reg = val;
  endtask

  task automatic set_shape(logic [3:0] rows_val, logic [3:0] cols_val);
    write_reg(REG_N_ROWS, rows_val);
    write_reg(REG_N_COLS, cols_val);
  endtask

  task automatic queue_element(logic [31:0] v, logic l);
    element_t e;
    e.value = v;
    e.last  = l;
    pending_q.push_back(e);
    items_queued++;
  endtask

  task automatic wait_drained();
    wait (pending_q.size() == 0 && !s_axis_tvalid && qr_expected.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic logic [31:0] random_element(int unsigned flavor);
    case (flavor)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 32'h80000)) - 32'sh40000);
      2: return 32'($signed($urandom_range(0, 32'h200)) - 32'sh100);
      default: return $urandom_range(0, 4) == 0 ? S32_MIN : S32_MAX;
    endcase
  endfunction

  initial begin
    int unsigned rows;
    int unsigned cols;
    int unsigned count;
    int unsigned flavor;
    int unsigned zero_col;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    rows_reg      = 4'd8;
    cols_reg      = 4'd8;
    load_idx      = 0;
    zero_norm     = 1'b0;
    error_count   = 0;
    items_queued  = 0;
    idle_cycles   = 0;
    elem_taken    = 1'b0;
    burst_left    = 0;
    gap_left      = 0;
    sink_cycle    = 0;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      col_mem[i]   = 0;
      upper_mem[i] = 0;
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // full 8x8 load at reset shape fills every column store entry
    for (int i = 0; i < 64; i++) queue_element($urandom(), i == 63);
    wait_drained();

    // 1x1 via clamping of zero rows and oversize cols
    set_shape(4'd0, 4'd15);
    queue_element(S32_MIN, 1'b1);
    queue_element(32'd0, 1'b1);
    queue_element(S32_MAX, 1'b1);
    wait_drained();

    // 2x2 with a zero first column
    set_shape(4'd2, 4'd2);
    queue_element(32'd0, 1'b0);
    queue_element(32'd0, 1'b0);
    queue_element(S32_MAX, 1'b0);
    queue_element(S32_MIN, 1'b1);
    wait_drained();

    // 3x3: too many elements, then too few
    set_shape(4'd3, 4'd3);
    for (int i = 0; i < 11; i++) queue_element(random_element(i % 4), i == 10);
    queue_element(32'h00010000, 1'b0);
    queue_element(32'hffff0000, 1'b1);
    wait_drained();

    // 8x1 from oversize rows and zero cols, square sum saturates
    set_shape(4'd15, 4'd0);
    for (int i = 0; i < 8; i++) queue_element(S32_MIN, i == 7);
    wait_drained();

    // shape change in the middle of a load, cols above rows
    set_shape(4'd4, 4'd2);
    for (int i = 0; i < 3; i++) queue_element(random_element(1), 1'b0);
    wait_drained();
    set_shape(4'd2, 4'd5);
    queue_element(random_element(1), 1'b1);
    wait_drained();

    // random matrices, mostly small shapes
    while (items_queued < ITEM_TARGET) begin
      rows = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
      cols = $urandom_range(1, rows);
      if ($urandom_range(0, 7) == 0) begin
        set_shape($urandom_range(0, 15), $urandom_range(0, 15));
      end else begin
        set_shape(rows, cols);
      end
      rows   = rows_in_use();
      cols   = cols_in_use();
      count  = rows * cols;
      if ($urandom_range(0, 5) == 0) count = $urandom_range(1, count + 2);
      flavor   = $urandom_range(0, 3);
      zero_col = ($urandom_range(0, 5) == 0) ? $urandom_range(0, cols - 1) : MAX_COLS;
      for (int i = 0; i < count; i++) begin
        if (i / rows == zero_col) queue_element(32'd0, i == count - 1);
        else queue_element(random_element(($urandom_range(0, 4) == 0) ? $urandom_range(0, 3)
                                                                      : flavor),
                           i == count - 1);
      end
      wait_drained();
    end

    if (error_count == 0) begin
      $display("gram_schmidt_qr_decompose test passed");
    end else begin
      $display("gram_schmidt_qr_decompose test failed");
    end
    $finish;
  end

endmodule

// File: gram_schmidt_qr_decompose.f
rtl/gsqr_pkg.sv
rtl/gsqr_dp.sv
rtl/gsqr_ctrl.sv
rtl/gram_schmidt_qr_decompose.sv
sim/gram_schmidt_qr_decompose_tb.sv
